// ----- rtl/tccw_pkg.sv -----
// Shared constants, types and state codes for the text console character writer.
package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Address width wide enough for up to 32768 screen cells.
  localparam int ADDR_W = 15;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_RDWAIT = 6'b001000,
    S_BLANK  = 6'b010000,
    S_DONE   = 6'b100000
  } tccw_state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
  } tccw_mem_req_t;

  typedef struct packed {
    logic [15:0] word;
    logic [4:0]  line;
    logic [6:0]  column;
  } tccw_res_t;

endpackage

// ----- rtl/tccw_screen.sv -----
// Screen cell memory: one write or one registered read per cycle.
module tccw_screen
  import tccw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic          clk,
  input  tccw_mem_req_t mem_req,
  output logic [15:0]   rdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [15:0] cells [CELLS];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      cells[mem_req.addr[AW-1:0]] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rdata <= cells[mem_req.addr[AW-1:0]];
    end
  end

endmodule

// ----- rtl/tccw_seq.sv -----
// Request sequencer: cursor, scroll offset, clear and blank sweeps, cell access.
module tccw_seq
  import tccw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [7:0]    in_char_code,
  input  logic [4:0]    in_read_row,
  input  logic [6:0]    in_read_column,
  input  logic [7:0]    attr,
  output tccw_mem_req_t mem_req,
  input  logic [15:0]   mem_rdata,
  output logic          res_valid,
  input  logic          res_ready,
  output tccw_res_t     res
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);

  localparam logic [AW-1:0] CELLS_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
  localparam logic [AW-1:0] COLS_LAST  = AW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
  localparam logic [RW:0]   ROWS_X     = (RW + 1)'(ROWS);
  localparam logic [CW-1:0] COL_END    = CW'(COLUMNS);

  tccw_state_t   state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] sweep_row_r, sweep_row_nxt;
  logic          pend_r, pend_nxt;
  logic [15:0]   val_r, val_nxt;
  logic          op_r;
  logic [7:0]    ch_r;
  logic [4:0]    rr_r;
  logic [6:0]    rc_r;

  logic [RW-1:0] lrow;
  logic [CW-1:0] lcol;
  logic [RW:0]   psum;
  logic [RW-1:0] prow;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] sweep_addr;
  logic [15:0]   blank;
  logic [15:0]   chword;
  logic          rd_ok;
  logic          wrap;
  logic          at_last;
  logic [RW-1:0] top_inc;

  assign blank   = {attr, CH_SPACE};
  assign chword  = {attr, ch_r};
  assign rd_ok   = (32'(rr_r) < ROWS) && (32'(rc_r) < COLUMNS);
  assign wrap    = (col_r == COL_END);
  assign at_last = (row_r == ROW_LAST);
  assign top_inc = (top_r == ROW_LAST) ? '0 : top_r + RW'(1);

  // Logical cell addressed in EXEC, mapped through the scroll offset.
  always_comb begin
    if (op_r == OP_READ) begin
      lrow = RW'(rr_r);
      lcol = CW'(rc_r);
    end else if (ch_r == CH_BACKSPACE) begin
      lrow = row_r;
      lcol = col_r - CW'(1);
    end else if (wrap) begin
      lrow = row_r + RW'(1);
      lcol = '0;
    end else begin
      lrow = row_r;
      lcol = col_r;
    end
  end

  assign psum       = {1'b0, top_r} + {1'b0, lrow};
  assign prow       = (psum >= ROWS_X) ? RW'(psum - ROWS_X) : psum[RW-1:0];
  assign cell_addr  = AW'(prow) * COLS_A + AW'(lcol);
  assign sweep_addr = AW'(sweep_row_r) * COLS_A + cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    top_nxt       = top_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sweep_row_nxt = sweep_row_r;
    pend_nxt      = pend_r;
    val_nxt       = val_r;
    mem_req       = '0;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_W'(cnt_r);
        mem_req.wdata = {RESET_ATTR, CH_SPACE};
        cnt_nxt       = cnt_r + AW'(1);
        if (cnt_r == CELLS_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        val_nxt   = '0;
        if (op_r == OP_READ) begin
          if (rd_ok) begin
            mem_req.re   = 1'b1;
            mem_req.addr = ADDR_W'(cell_addr);
            state_nxt    = S_RDWAIT;
          end
        end else if (ch_r == CH_BACKSPACE) begin
          if (col_r != '0) begin
            col_nxt       = lcol;
            val_nxt       = blank;
            mem_req.we    = 1'b1;
            mem_req.addr  = ADDR_W'(cell_addr);
            mem_req.wdata = blank;
          end
        end else if (ch_r == CH_NEWLINE) begin
          col_nxt = '0;
          if (at_last) begin
            top_nxt       = top_inc;
            sweep_row_nxt = top_r;
            pend_nxt      = 1'b0;
            cnt_nxt       = '0;
            state_nxt     = S_BLANK;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          val_nxt = chword;
          if (wrap && at_last) begin
            col_nxt       = CW'(1);
            top_nxt       = top_inc;
            sweep_row_nxt = top_r;
            pend_nxt      = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = S_BLANK;
          end else begin
            if (wrap) begin
              row_nxt = row_r + RW'(1);
            end
            col_nxt       = lcol + CW'(1);
            mem_req.we    = 1'b1;
            mem_req.addr  = ADDR_W'(cell_addr);
            mem_req.wdata = chword;
          end
        end
      end
      S_RDWAIT: begin
        val_nxt   = mem_rdata;
        state_nxt = S_DONE;
      end
      S_BLANK: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_W'(sweep_addr);
        mem_req.wdata = (cnt_r == '0 && pend_r) ? val_r : blank;
        cnt_nxt       = cnt_r + AW'(1);
        if (cnt_r == COLS_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.word   = val_r;
  assign res.line   = 5'(row_r);
  assign res.column = 7'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      top_r   <= '0;
      row_r   <= RW'(1);
      col_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      top_r   <= top_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sweep_row_r <= sweep_row_nxt;
    val_r       <= val_nxt;
    if (in_valid && in_ready) begin
      op_r <= in_op;
      ch_r <= in_char_code;
      rr_r <= in_read_row;
      rc_r <= in_read_column;
    end
  end

endmodule

// ----- rtl/text_console_character_writer.sv -----
// Text console character writer: top level with attribute register and output stage.
//
// Input requests (in_valid/in_ready) carry an op: write writes in_char_code at
// the cursor (backspace and newline are handled as cursor moves), read returns
// the cell at in_read_row/in_read_column. Every request gives one result on
// out_valid/out_ready: the cell value plus the cursor position after the step.
// cfg_we loads the attribute byte used for written and blanked cells.
// Requests are handled one at a time: a plain write goes from accept through
// EXEC to DONE, an in-range read also passes RDWAIT (registered memory read),
// and a write that scrolls passes BLANK, where the bottom row is blanked one
// cell per cycle through the single memory port. Scrolling itself moves no data:
// a row offset register rotates the logical screen over the physical rows.
// After reset the block clears all ROWS * COLUMNS cells, one per cycle, with
// in_ready low; cursor resets to row 1, column 0, attribute to 0x0F.
// The output register holds a result until taken; the next request is accepted
// meanwhile, and its result waits in the sequencer while out_ready stays low.
module text_console_character_writer
  import tccw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cell_value,
  output logic [4:0]  out_cursor_line,
  output logic [6:0]  out_cursor_column,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int CELLS = ROWS * COLUMNS;

  logic [7:0]    attr_r;
  logic          out_valid_r;
  tccw_res_t     out_r;
  tccw_mem_req_t mem_req;
  logic [15:0]   mem_rdata;
  logic          res_valid;
  logic          res_ready;
  tccw_res_t     res;

  tccw_seq #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_char_code  (in_char_code),
    .in_read_row   (in_read_row),
    .in_read_column(in_read_column),
    .attr          (attr_r),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  tccw_screen #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_screen (
    .clk    (clk),
    .mem_req(mem_req),
    .rdata  (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_value    = out_r.word;
  assign out_cursor_line   = out_r.line;
  assign out_cursor_column = out_r.column;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("memory read and write in the same cycle");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we || mem_req.re) |-> (32'(mem_req.addr) < CELLS))
    else $error("memory address out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_cell_value)))
    else $error("pending result overwritten");

endmodule

// ----- bench/tb_text_console_character_writer.sv -----
// Testbench for the text console character writer: directed table, random phases, scoreboard.
module tb_text_console_character_writer;
  import tccw_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int IDLE_WAIT = COLS + 8;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 300;
  localparam int PHASE_REQUESTS = 500;
  localparam int NUM_DIRECTED = 25;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] reps;
    logic       typed;
    logic [15:0] word;
    logic [4:0]  line;
    logic [6:0]  column;
  } stim_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  // rows with typed set are checked against the values given here
  localparam stim_row_t DIRECTED_STIM [NUM_DIRECTED] = '{
    '{OP_READ,  8'h00,        5'd0,  7'd0,   8'd1,  1'b1, 16'h0F20, 5'd1,  7'd0},
    '{OP_READ,  8'hFF,        5'd24, 7'd79,  8'd1,  1'b1, 16'h0F20, 5'd1,  7'd0},
    '{OP_READ,  8'h00,        5'd25, 7'd0,   8'd1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_READ,  8'h00,        5'd0,  7'd80,  8'd1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_READ,  8'h00,        5'd31, 7'd127, 8'd1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_WRITE, CH_BACKSPACE, 5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_WRITE, 8'h00,        5'd31, 7'd127, 8'd1,  1'b1, 16'h0F00, 5'd1,  7'd1},
    '{OP_WRITE, 8'hFF,        5'd0,  7'd0,   8'd1,  1'b1, 16'h0FFF, 5'd1,  7'd2},
    '{OP_WRITE, CH_BACKSPACE, 5'd0,  7'd0,   8'd1,  1'b1, 16'h0F20, 5'd1,  7'd1},
    '{OP_READ,  8'h00,        5'd1,  7'd1,   8'd1,  1'b1, 16'h0F20, 5'd1,  7'd1},
    '{OP_READ,  CH_NEWLINE,   5'd1,  7'd0,   8'd1,  1'b1, 16'h0F00, 5'd1,  7'd1},
    '{OP_WRITE, CH_NEWLINE,   5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd2,  7'd0},
    '{OP_WRITE, 8'h41,        5'd31, 7'd127, 8'd1,  1'b1, 16'h0F41, 5'd2,  7'd1},
    '{OP_WRITE, 8'h42,        5'd0,  7'd0,   8'd79, 1'b0, 16'h0000, 5'd0,  7'd0},
    '{OP_READ,  8'h00,        5'd2,  7'd79,  8'd1,  1'b1, 16'h0F42, 5'd2,  7'd80},
    '{OP_WRITE, CH_BACKSPACE, 5'd0,  7'd0,   8'd1,  1'b1, 16'h0F20, 5'd2,  7'd79},
    '{OP_WRITE, 8'h43,        5'd0,  7'd0,   8'd1,  1'b1, 16'h0F43, 5'd2,  7'd80},
    '{OP_WRITE, 8'h44,        5'd0,  7'd0,   8'd1,  1'b1, 16'h0F44, 5'd3,  7'd1},
    '{OP_WRITE, CH_NEWLINE,   5'd0,  7'd0,   8'd21, 1'b0, 16'h0000, 5'd0,  7'd0},
    '{OP_WRITE, 8'h45,        5'd0,  7'd0,   8'd1,  1'b1, 16'h0F45, 5'd24, 7'd1},
    '{OP_WRITE, CH_NEWLINE,   5'd0,  7'd0,   8'd1,  1'b1, 16'h0000, 5'd24, 7'd0},
    '{OP_READ,  8'h00,        5'd23, 7'd0,   8'd1,  1'b1, 16'h0F45, 5'd24, 7'd0},
    '{OP_READ,  8'h00,        5'd24, 7'd0,   8'd1,  1'b1, 16'h0F20, 5'd24, 7'd0},
    '{OP_READ,  8'h00,        5'd0,  7'd0,   8'd1,  1'b1, 16'h0F00, 5'd24, 7'd0},
    '{OP_WRITE, 8'h46,        5'd0,  7'd0,   8'd85, 1'b0, 16'h0000, 5'd0,  7'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [7:0]  in_char_code;
  logic [4:0]  in_read_row;
  logic [6:0]  in_read_column;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_cell_value;
  logic [4:0]  out_cursor_line;
  logic [6:0]  out_cursor_column;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  logic [15:0] screen_model [ROWS*COLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  attr_model;
  tccw_res_t   pending_results [$];
  int          errors;
  int          results_seen;
  int          burst_left;

  text_console_character_writer #(.COLUMNS(COLS), .ROWS(ROWS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_char_code(in_char_code), .in_read_row(in_read_row),
    .in_read_column(in_read_column),
    .out_valid(out_valid), .out_ready(out_ready), .out_cell_value(out_cell_value),
    .out_cursor_line(out_cursor_line), .out_cursor_column(out_cursor_column),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int c = 0; c < COLS; c++) screen_model[(ROWS - 1) * COLS + c] = {attr_model, CH_SPACE};
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic tccw_res_t predict_console(logic op, logic [7:0] ch, logic [4:0] rr,
                                                logic [6:0] rc);
    tccw_res_t r;
    r.word = 16'h0000;
    if (op == OP_READ) begin
      if (rr < ROWS && rc < COLS) r.word = screen_model[rr * COLS + rc];
    end else if (ch == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        r.word = {attr_model, CH_SPACE};
        screen_model[cur_row * COLS + cur_col] = r.word;
      end
    end else if (ch == CH_NEWLINE) begin
      advance_line();
    end else begin
      if (cur_col >= COLS) advance_line();
      r.word = {attr_model, ch};
      screen_model[cur_row * COLS + cur_col] = r.word;
      cur_col++;
    end
    r.line = cur_row[4:0];
    r.column = cur_col[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // called just after a rising edge; returns at the edge that accepts the request
  task automatic send_request(logic op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc,
                              logic typed, tccw_res_t typed_res);
    int gap;
    tccw_res_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_char_code <= ch;
    in_read_row <= rr;
    in_read_column <= rc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_console(op, ch, rr, rc);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic set_attribute(logic [7:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    attr_model = value;
  endtask

  task automatic run_random_phase(int count);
    int pick;
    logic op;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    tccw_res_t none;
    none = '0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      op = OP_WRITE;
      ch = 8'($urandom_range(0, 255));
      rr = 5'($urandom_range(0, 31));
      rc = 7'($urandom_range(0, 127));
      if (pick < 18) begin
        op = OP_READ;
        rr = 5'($urandom_range(0, ROWS - 1));
        rc = 7'($urandom_range(0, COLS - 1));
      end else if (pick < 22) begin
        op = OP_READ;
      end else if (pick < 28) begin
        ch = CH_NEWLINE;
      end else if (pick < 34) begin
        ch = CH_BACKSPACE;
      end else if (pick >= 38) begin
        ch = 8'($urandom_range(8'h20, 8'h7E));
      end
      send_request(op, ch, rr, rc, 1'b0, none);
    end
  endtask

  // result side: stall patterns, one long hold-off, scoreboard check
  initial begin
    rx_mode_t mode;
    int mode_left;
    int cycle;
    bit held;
    tccw_res_t want;
    mode = RX_OPEN;
    mode_left = 0;
    cycle = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", out_cell_value, 16'h0000);
        end else begin
          want = pending_results.pop_front();
          if (out_cell_value !== want.word)
            report_mismatch("cell_value", out_cell_value, want.word);
          if (out_cursor_line !== want.line)
            report_mismatch("cursor_line", 16'(out_cursor_line), 16'(want.line));
          if (out_cursor_column !== want.column)
            report_mismatch("cursor_column", 16'(out_cursor_column), 16'(want.column));
        end
      end
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (cycle % 4 == 0);
        default:   out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    tccw_res_t typed_res;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_WRITE;
    in_char_code <= 8'h00;
    in_read_row <= 5'd0;
    in_read_column <= 7'd0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 8'h00;
    errors = 0;
    results_seen = 0;
    burst_left = 0;
    for (int i = 0; i < ROWS * COLS; i++) screen_model[i] = {RESET_ATTR, CH_SPACE};
    cur_row = 1;
    cur_col = 0;
    attr_model = RESET_ATTR;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED_STIM[i];
      typed_res.word = row.word;
      typed_res.line = row.line;
      typed_res.column = row.column;
      for (int k = 0; k < row.reps; k++)
        send_request(row.op, row.ch, row.row, row.col, row.typed, typed_res);
    end

    set_attribute(8'h00);
    run_random_phase(PHASE_REQUESTS);
    set_attribute(8'hFF);
    run_random_phase(PHASE_REQUESTS);
    set_attribute(8'($urandom_range(0, 255)));
    run_random_phase(PHASE_REQUESTS);
    set_attribute(8'($urandom_range(0, 255)));
    run_random_phase(PHASE_REQUESTS);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
